FILE: hw/rtl/conv3x3_valid_stream_unit_macros.svh
// Assertion macros shared by the checker files of the 3x3 convolution unit.
`ifndef CONV3X3_VALID_STREAM_UNIT_MACROS_SVH
`define CONV3X3_VALID_STREAM_UNIT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define C3VS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies an expression in the next cycle.
`define C3VS_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

FILE: hw/rtl/c3vs_pkg.sv
// Package of the 3x3 convolution unit: sizes, register codes, shared types and helpers.
package c3vs_pkg;

  // Geometry and arithmetic sizes.
  localparam int MAX_WIDTH     = 1024;
  localparam int SAMPLE_BITS   = 16;
  localparam int KERNEL_SIZE   = 3;
  localparam int COEF_BITS     = 8;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int ROW_BITS      = 16;
  localparam int WIDTH_BITS    = 11;
  localparam int KROW_BITS     = KERNEL_SIZE * COEF_BITS;
  localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;
  localparam int RSUM_BITS     = PROD_BITS + 2;
  localparam int RESULT_BITS   = 27;
  localparam int LB_BITS       = 2 * SAMPLE_BITS;
  localparam int MIN_DIM       = 3;

  // Output queue sizes.
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

  // Configuration port sizes.
  localparam int ADDR_BITS     = 5;
  localparam int DATA_BITS     = 32;

  // Register reset values.
  localparam logic [KROW_BITS-1:0]  KROW0_RESET  = 24'h000001;
  localparam logic [KROW_BITS-1:0]  KROW1_RESET  = 24'h000100;
  localparam logic [KROW_BITS-1:0]  KROW2_RESET  = 24'h010000;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = 11'd10;
  localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = 16'd10;

  // Register index codes (word address).
  typedef enum logic [2:0] {
    REG_KERNEL_ROW0  = 3'd0,
    REG_KERNEL_ROW1  = 3'd1,
    REG_KERNEL_ROW2  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } reg_idx_t;

  // Three kernel rows, column 0 in the low byte of each row.
  typedef logic [KERNEL_SIZE-1:0][KROW_BITS-1:0] kernel_t;

  // Control that travels with a sample into the window stage.
  typedef struct packed {
    logic shift;
    logic produce;
    logic last;
  } win_ctl_t;

  // One finished result.
  typedef struct packed {
    logic signed [RESULT_BITS-1:0] value;
    logic                          last;
  } result_t;

  // Coefficient of kernel row r, column c.
  function automatic logic signed [COEF_BITS-1:0] coef(kernel_t k, int r, int c);
    return k[r][COEF_BITS*c +: COEF_BITS];
  endfunction

endpackage

FILE: hw/rtl/conv3x3_valid_stream_unit.sv
// Top level of the streaming 3x3 valid-region convolution unit.
// The unit takes one signed 16-bit sample per clock while sample_ready is high, in raster order,
// and gives one 27-bit result for every sample whose row and column are both at least 2, so a W
// by H frame yields (W-2) by (H-2) results, the last one flagged by frame_last. Sustained rate is
// one sample per cycle, set by the single line buffer memory that is read and written once per
// sample. A result passes the sample, window, product and row-sum registers and then waits in an
// eight-entry output queue; sample_ready drops while eight samples are in flight or queued. The
// line buffer needs no clearing pass after reset. Width is clamped to 3..1024 and height raised
// to at least 3; the kernel, width and height registers are written through the APB port, and the
// user must write them only while the unit is idle; the unit itself does not enforce this.
module conv3x3_valid_stream_unit (
  input  logic                                    clk,
  input  logic                                    rst,
  // Sample channel.
  input  logic                                    sample_valid,
  output logic                                    sample_ready,
  input  logic signed [c3vs_pkg::SAMPLE_BITS-1:0] sample,
  // Result channel.
  output logic                                    result_valid,
  input  logic                                    result_ready,
  output logic signed [c3vs_pkg::RESULT_BITS-1:0] conv_value,
  output logic                                    frame_last,
  // Configuration port.
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [c3vs_pkg::ADDR_BITS-1:0]          paddr,
  input  logic [c3vs_pkg::DATA_BITS-1:0]          pwdata,
  output logic [c3vs_pkg::DATA_BITS-1:0]          prdata,
  output logic                                    pready
);

  logic [c3vs_pkg::KROW_BITS-1:0]     kernel_row0;
  logic [c3vs_pkg::KROW_BITS-1:0]     kernel_row1;
  logic [c3vs_pkg::KROW_BITS-1:0]     kernel_row2;
  logic [c3vs_pkg::WIDTH_BITS-1:0]    image_width;
  logic [c3vs_pkg::ROW_BITS-1:0]      image_height;
  c3vs_pkg::reg_idx_t                 reg_idx;
  logic                               cfg_write;

  logic [c3vs_pkg::COL_BITS-1:0]      w_m1;
  logic [c3vs_pkg::ROW_BITS-1:0]      h_m1;
  logic [c3vs_pkg::COL_BITS-1:0]      column_count;
  logic [c3vs_pkg::ROW_BITS-1:0]      row_count;
  logic                               row_end;
  logic                               frame_end;
  logic                               produce;
  logic                               in_fire;
  logic                               out_fire;

  logic                               s1_valid;
  logic signed [c3vs_pkg::SAMPLE_BITS-1:0] s1_sample;
  logic [c3vs_pkg::COL_BITS-1:0]      s1_col;
  logic                               s1_produce;
  logic                               s1_last;
  logic [c3vs_pkg::LB_BITS-1:0]       lb_rd_data;
  logic                               drop;

  logic [c3vs_pkg::FIFO_CNT_BITS-1:0] occ;
  logic [c3vs_pkg::FIFO_CNT_BITS-1:0] occ_next;

  c3vs_pkg::win_ctl_t                 win_ctl;
  c3vs_pkg::kernel_t                  kernel;
  logic                               res_valid;
  c3vs_pkg::result_t                  res;
  c3vs_pkg::result_t                  head;

  // Configuration write decode.
  assign pready    = 1'b1;
  assign reg_idx   = c3vs_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_row0  <= c3vs_pkg::KROW0_RESET;
      kernel_row1  <= c3vs_pkg::KROW1_RESET;
      kernel_row2  <= c3vs_pkg::KROW2_RESET;
      image_width  <= c3vs_pkg::WIDTH_RESET;
      image_height <= c3vs_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        c3vs_pkg::REG_KERNEL_ROW0:  kernel_row0  <= pwdata[c3vs_pkg::KROW_BITS-1:0];
        c3vs_pkg::REG_KERNEL_ROW1:  kernel_row1  <= pwdata[c3vs_pkg::KROW_BITS-1:0];
        c3vs_pkg::REG_KERNEL_ROW2:  kernel_row2  <= pwdata[c3vs_pkg::KROW_BITS-1:0];
        c3vs_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[c3vs_pkg::WIDTH_BITS-1:0];
        c3vs_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[c3vs_pkg::ROW_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      c3vs_pkg::REG_KERNEL_ROW0:  prdata = c3vs_pkg::DATA_BITS'(kernel_row0);
      c3vs_pkg::REG_KERNEL_ROW1:  prdata = c3vs_pkg::DATA_BITS'(kernel_row1);
      c3vs_pkg::REG_KERNEL_ROW2:  prdata = c3vs_pkg::DATA_BITS'(kernel_row2);
      c3vs_pkg::REG_IMAGE_WIDTH:  prdata = c3vs_pkg::DATA_BITS'(image_width);
      c3vs_pkg::REG_IMAGE_HEIGHT: prdata = c3vs_pkg::DATA_BITS'(image_height);
      default:                    prdata = '0;
    endcase
  end

  // Effective last column and last row of the frame.
  always_comb begin
    if (image_width < c3vs_pkg::WIDTH_BITS'(c3vs_pkg::MIN_DIM)) begin
      w_m1 = c3vs_pkg::COL_BITS'(c3vs_pkg::MIN_DIM - 1);
    end else if (image_width > c3vs_pkg::WIDTH_BITS'(c3vs_pkg::MAX_WIDTH)) begin
      w_m1 = c3vs_pkg::COL_BITS'(c3vs_pkg::MAX_WIDTH - 1);
    end else begin
      w_m1 = c3vs_pkg::COL_BITS'(image_width - 1'b1);
    end
    if (image_height < c3vs_pkg::ROW_BITS'(c3vs_pkg::MIN_DIM)) begin
      h_m1 = c3vs_pkg::ROW_BITS'(c3vs_pkg::MIN_DIM - 1);
    end else begin
      h_m1 = image_height - 1'b1;
    end
  end

  // Raster position of the sample on the channel.
  assign in_fire   = sample_valid & sample_ready;
  assign out_fire  = result_valid & result_ready;
  assign row_end   = (column_count >= w_m1);
  assign frame_end = row_end && (row_count >= h_m1);
  assign produce   = (row_count >= c3vs_pkg::ROW_BITS'(2))
                  && (column_count >= c3vs_pkg::COL_BITS'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // Sample stage: hold the beat while the line buffer read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample  <= sample;
      s1_col     <= column_count;
      s1_produce <= produce;
      s1_last    <= frame_end;
    end
  end

  // Line buffer: read the column on the beat, write the shifted rows in the next cycle.
  c3vs_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (column_count),
    .rd_data (lb_rd_data),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data ({lb_rd_data[c3vs_pkg::SAMPLE_BITS-1:0], s1_sample})
  );

  // Window and multiply-accumulate pipeline.
  assign win_ctl.shift   = s1_valid;
  assign win_ctl.produce = s1_produce;
  assign win_ctl.last    = s1_last;
  assign kernel          = {kernel_row2, kernel_row1, kernel_row0};

  c3vs_window_mac u_window_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (win_ctl),
    .up        (lb_rd_data[c3vs_pkg::LB_BITS-1:c3vs_pkg::SAMPLE_BITS]),
    .mid       (lb_rd_data[c3vs_pkg::SAMPLE_BITS-1:0]),
    .sample    (s1_sample),
    .kernel    (kernel),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output queue.
  c3vs_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .pop        (out_fire),
    .head_valid (result_valid),
    .head_data  (head)
  );

  assign conv_value = head.value;
  assign frame_last = head.last;

  // Credit count: beats taken whose result is not yet delivered or known to be absent.
  assign drop     = s1_valid & ~s1_produce;
  assign occ_next = occ + c3vs_pkg::FIFO_CNT_BITS'(in_fire)
                  - c3vs_pkg::FIFO_CNT_BITS'(out_fire)
                  - c3vs_pkg::FIFO_CNT_BITS'(drop);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  assign sample_ready = (occ < c3vs_pkg::FIFO_CNT_BITS'(c3vs_pkg::FIFO_DEPTH));

endmodule

FILE: hw/rtl/c3vs_line_buf.sv
// Line buffer memory holding the upper and middle rows side by side in one word.
module c3vs_line_buf (
  input  logic                             clk,
  input  logic                             rd_en,
  input  logic [c3vs_pkg::COL_BITS-1:0]    rd_addr,
  output logic [c3vs_pkg::LB_BITS-1:0]     rd_data,
  input  logic                             wr_en,
  input  logic [c3vs_pkg::COL_BITS-1:0]    wr_addr,
  input  logic [c3vs_pkg::LB_BITS-1:0]     wr_data
);

  // Upper row in the high half, middle row in the low half.
  logic [c3vs_pkg::LB_BITS-1:0] mem [c3vs_pkg::MAX_WIDTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/c3vs_window_mac.sv
// 3x3 window registers and the pipelined multiply and sum of nine products.
module c3vs_window_mac (
  input  logic                                    clk,
  input  logic                                    rst,
  input  c3vs_pkg::win_ctl_t                      ctl,
  input  logic signed [c3vs_pkg::SAMPLE_BITS-1:0] up,
  input  logic signed [c3vs_pkg::SAMPLE_BITS-1:0] mid,
  input  logic signed [c3vs_pkg::SAMPLE_BITS-1:0] sample,
  input  c3vs_pkg::kernel_t                       kernel,
  output logic                                    res_valid,
  output c3vs_pkg::result_t                       res
);

  localparam int K = c3vs_pkg::KERNEL_SIZE;

  logic signed [c3vs_pkg::SAMPLE_BITS-1:0] win  [K][K];
  logic signed [c3vs_pkg::PROD_BITS-1:0]   prod [K][K];
  logic signed [c3vs_pkg::RSUM_BITS-1:0]   rsum [K];
  logic w_valid, w_last;
  logic p_valid, p_last;
  logic r_valid, r_last;

  // Window shift: column 0 is the oldest, the new column enters at the right.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < K; i++) begin
        for (int j = 0; j < K; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (ctl.shift) begin
      for (int i = 0; i < K; i++) begin
        for (int j = 0; j < K - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
      end
      win[0][K-1] <= up;
      win[1][K-1] <= mid;
      win[2][K-1] <= sample;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
      p_valid <= 1'b0;
      r_valid <= 1'b0;
    end else begin
      w_valid <= ctl.shift & ctl.produce;
      p_valid <= w_valid;
      r_valid <= p_valid;
    end
  end

  // Nine products of the window taken right after its shift.
  always_ff @(posedge clk) begin
    w_last <= ctl.last;
    p_last <= w_last;
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        prod[i][j] <= win[i][j] * c3vs_pkg::coef(kernel, i, j);
      end
    end
  end

  // Sum of each kernel row.
  always_ff @(posedge clk) begin
    r_last <= p_last;
    for (int i = 0; i < K; i++) begin
      rsum[i] <= c3vs_pkg::RSUM_BITS'(prod[i][0]) + c3vs_pkg::RSUM_BITS'(prod[i][1])
               + c3vs_pkg::RSUM_BITS'(prod[i][2]);
    end
  end

  // Final sum of the three rows, written into the output queue.
  assign res_valid = r_valid;
  assign res.value = c3vs_pkg::RESULT_BITS'(rsum[0]) + c3vs_pkg::RESULT_BITS'(rsum[1])
                   + c3vs_pkg::RESULT_BITS'(rsum[2]);
  assign res.last  = r_last;

endmodule

FILE: hw/rtl/c3vs_out_fifo.sv
// Output queue of finished results in front of the result channel.
module c3vs_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  c3vs_pkg::result_t push_data,
  input  logic              pop,
  output logic              head_valid,
  output c3vs_pkg::result_t head_data
);

  c3vs_pkg::result_t                    fifo_mem [c3vs_pkg::FIFO_DEPTH];
  logic [c3vs_pkg::FIFO_PTR_BITS-1:0]   wr_ptr;
  logic [c3vs_pkg::FIFO_PTR_BITS-1:0]   rd_ptr;
  logic [c3vs_pkg::FIFO_CNT_BITS-1:0]   count;
  logic [c3vs_pkg::FIFO_CNT_BITS-1:0]   count_next;

  // Entry storage; the upstream credit count keeps the queue from overflowing.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= push_data;
    end
  end

  assign count_next = count + c3vs_pkg::FIFO_CNT_BITS'(push)
                    - c3vs_pkg::FIFO_CNT_BITS'(pop);

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  assign head_valid = (count != '0);
  assign head_data  = fifo_mem[rd_ptr];

endmodule

FILE: hw/rtl/c3vs_checker.sv
// Port-level checker of the 3x3 convolution unit and its bind to the top level.
`include "conv3x3_valid_stream_unit_macros.svh"

module c3vs_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    sample_ready,
  input logic                                    result_valid,
  input logic                                    result_ready,
  input logic signed [c3vs_pkg::RESULT_BITS-1:0] conv_value,
  input logic                                    frame_last,
  input logic                                    psel,
  input logic                                    penable,
  input logic                                    pwrite,
  input logic [c3vs_pkg::ADDR_BITS-1:0]          paddr,
  input logic [c3vs_pkg::DATA_BITS-1:0]          pwdata,
  input logic [c3vs_pkg::DATA_BITS-1:0]          prdata,
  input logic                                    pready
);

  // A stalled result beat keeps its payload.
  `C3VS_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(conv_value) && $stable(frame_last), "result beat changed while stalled")

  // Right after reset no result is pending and samples are taken.
  `C3VS_ASSERT(a_reset_idle, clk, rst, $past(rst) |-> !result_valid && sample_ready, "unit not idle after reset")

  // Kernel row 0 written in one cycle reads back in the next.
  `C3VS_ASSERT(a_kernel_readback, clk, rst, (psel && penable && pwrite && pready && paddr[4:2] == c3vs_pkg::REG_KERNEL_ROW0) ##1 (psel && !pwrite && paddr[4:2] == c3vs_pkg::REG_KERNEL_ROW0) |-> prdata[23:0] == $past(pwdata[23:0]), "kernel row read-back mismatch")

  // The width register reads back with its unused upper bits clear.
  `C3VS_ASSERT(a_width_upper_zero, clk, rst, (psel && !pwrite && paddr[4:2] == c3vs_pkg::REG_IMAGE_WIDTH) |-> prdata[31:11] == '0, "width read-back has upper bits set")

endmodule

bind conv3x3_valid_stream_unit c3vs_checker u_c3vs_checker (.*);

FILE: tb/conv3x3_valid_stream_unit_tb.sv
// Self-checking testbench for the streaming 3x3 valid-region convolution unit.
`timescale 1ns / 1ps

module conv3x3_valid_stream_unit_tb;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_ITEMS   = 240;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam int KS   = c3vs_pkg::KERNEL_SIZE;
  localparam int SB   = c3vs_pkg::SAMPLE_BITS;
  localparam int RB   = c3vs_pkg::RESULT_BITS;
  localparam int DB   = c3vs_pkg::DATA_BITS;
  localparam int KB   = c3vs_pkg::KROW_BITS;
  localparam int WB   = c3vs_pkg::WIDTH_BITS;
  localparam int HB   = c3vs_pkg::ROW_BITS;
  localparam int CB   = c3vs_pkg::COEF_BITS;
  localparam int MAXW = c3vs_pkg::MAX_WIDTH;
  localparam int MIND = c3vs_pkg::MIN_DIM;

  // Predicts the convolution results and holds the ones not yet seen.
  class conv_scoreboard;
    logic [KB-1:0]             kernel_rows [KS];
    logic [WB-1:0]             width_reg;
    logic [HB-1:0]             height_reg;
    logic signed [SB-1:0]      upper_line [MAXW];
    logic signed [SB-1:0]      middle_line [MAXW];
    logic signed [SB-1:0]      taps [KS][KS];
    int unsigned               col_count;
    int unsigned               row_count;
    c3vs_pkg::result_t         expected_sums [$];
    int                        errors;

    function new();
      kernel_rows[0] = c3vs_pkg::KROW0_RESET;
      kernel_rows[1] = c3vs_pkg::KROW1_RESET;
      kernel_rows[2] = c3vs_pkg::KROW2_RESET;
      width_reg      = c3vs_pkg::WIDTH_RESET;
      height_reg     = c3vs_pkg::HEIGHT_RESET;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (taps[i, j]) taps[i][j] = '0;
      col_count = 0;
      row_count = 0;
      errors    = 0;
    endfunction

    // Mirrors a register write; the value is already cut to the register width.
    function void set_reg(c3vs_pkg::reg_idx_t idx, logic [DB-1:0] value);
      case (idx)
        c3vs_pkg::REG_KERNEL_ROW0:  kernel_rows[0] = value[KB-1:0];
        c3vs_pkg::REG_KERNEL_ROW1:  kernel_rows[1] = value[KB-1:0];
        c3vs_pkg::REG_KERNEL_ROW2:  kernel_rows[2] = value[KB-1:0];
        c3vs_pkg::REG_IMAGE_WIDTH:  width_reg      = value[WB-1:0];
        c3vs_pkg::REG_IMAGE_HEIGHT: height_reg     = value[HB-1:0];
        default: ;
      endcase
    endfunction

    // Advances the line buffers and window by one accepted sample beat.
    function void accept_sample(logic signed [SB-1:0] s);
      int unsigned          w;
      int unsigned          h;
      int unsigned          c;
      logic signed [SB-1:0] up;
      logic signed [SB-1:0] mid;
      logic signed [CB-1:0] k;
      longint               acc;
      bit                   row_end;
      bit                   frame_end;
      c3vs_pkg::result_t    r;

      w = width_reg;
      if (w < MIND) w = MIND;
      if (w > MAXW) w = MAXW;
      h = height_reg;
      if (h < MIND) h = MIND;
      c = col_count;
      if (c >= MAXW) c = MAXW - 1;

      // Both line buffers shift down by one row at this column.
      up             = upper_line[c];
      mid            = middle_line[c];
      upper_line[c]  = mid;
      middle_line[c] = s;

      // The window moves one column left and takes the new column on the right.
      for (int i = 0; i < KS; i++) begin
        for (int j = 0; j < KS - 1; j++) taps[i][j] = taps[i][j + 1];
      end
      taps[0][KS-1] = up;
      taps[1][KS-1] = mid;
      taps[2][KS-1] = s;

      row_end   = (c >= w - 1);
      frame_end = row_end && (row_count >= h - 1);

      // A result exists once the window lies fully inside the frame.
      if (row_count >= 2 && c >= 2) begin
        acc = 0;
        for (int i = 0; i < KS; i++) begin
          for (int j = 0; j < KS; j++) begin
            k   = kernel_rows[i][CB*j +: CB];
            acc += longint'(taps[i][j]) * longint'(k);
          end
        end
        r.value = acc[RB-1:0];
        r.last  = frame_end;
        expected_sums.push_back(r);
      end

      if (row_end) begin
        col_count = 0;
        row_count = frame_end ? 0 : ((row_count + 1) & 32'hFFFF);
      end else begin
        col_count = c + 1;
      end
    endfunction

    // Compares one accepted result beat with the oldest prediction.
    function void check_result(logic signed [RB-1:0] value, logic last);
      c3vs_pkg::result_t e;
      if (expected_sums.size() == 0) begin
        $error("conv_value: no result expected, actual %0d", value);
        errors++;
        return;
      end
      e = expected_sums.pop_front();
      if (value !== e.value) begin
        $error("conv_value: expected %0d, actual %0d", e.value, value);
        errors++;
      end
      if (last !== e.last) begin
        $error("frame_last: expected %0b, actual %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                sample_valid = 1'b0;
  logic                                sample_ready;
  logic signed [SB-1:0]                sample = '0;
  logic                                result_valid;
  logic                                result_ready = 1'b0;
  logic signed [RB-1:0]                conv_value;
  logic                                frame_last;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [c3vs_pkg::ADDR_BITS-1:0]      paddr = '0;
  logic [DB-1:0]                       pwdata = '0;
  logic [DB-1:0]                       prdata;
  logic                                pready;

  conv_scoreboard sb = new();
  int             in_gap_max = 5;
  int             out_gap_max = 5;
  int             samples_sent = 0;
  int             idle_cycles = 0;

  conv3x3_valid_stream_unit dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Random sample with the two extremes drawn often.
  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return SB'($urandom);
    endcase
  endfunction

  // Random kernel row; the upper bits of the word are junk that must be dropped.
  function automatic logic [DB-1:0] rand_kernel_row();
    case ($urandom_range(0, 5))
      0:       return 32'h0080_8080;
      1:       return 32'h007F_7F7F;
      2:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Sends one sample beat after a random gap; valid stays high for back-to-back beats.
  task automatic send_sample(input logic signed [SB-1:0] s);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (!sample_ready);
    sb.accept_sample(s);
    samples_sent++;
  endtask

  // Sends samples until the frame in progress is complete.
  task automatic finish_frame();
    do send_sample(rand_sample());
    while (sb.col_count != 0 || sb.row_count != 0);
  endtask

  // Stops the sample stream and waits until the unit has nothing left in flight.
  task automatic settle();
    sample_valid <= 1'b0;
    while (sb.expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one register over the APB port and reads it back.
  task automatic write_reg(input c3vs_pkg::reg_idx_t idx, input logic [DB-1:0] value);
    logic [DB-1:0] stored;
    case (idx)
      c3vs_pkg::REG_IMAGE_WIDTH:  stored = DB'(value[WB-1:0]);
      c3vs_pkg::REG_IMAGE_HEIGHT: stored = DB'(value[HB-1:0]);
      default:                    stored = DB'(value[KB-1:0]);
    endcase

    // Write: setup cycle, then access cycle until pready.
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, stored);

    // Read back the same register.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) begin
      $error("prdata: expected %h, actual %h", stored, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random stall before each beat.
  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  // Every result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(conv_value, frame_last);
  end

  // Ends the run if no beat and no register access happens for too long.
  always @(posedge clk) begin
    if (rst || psel || (sample_valid && sample_ready) || (result_valid && result_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int start;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: identity-diagonal kernel on a 10 by 10 frame.
    finish_frame();
    settle();

    // Largest positive and negative sums on the smallest frame.
    write_reg(c3vs_pkg::REG_IMAGE_WIDTH, 32'd3);
    write_reg(c3vs_pkg::REG_IMAGE_HEIGHT, 32'd3);
    for (int r = 0; r < KS; r++) write_reg(c3vs_pkg::reg_idx_t'(r), 32'h0080_8080);
    repeat (9) send_sample(16'sh8000);
    repeat (9) send_sample(16'sh7FFF);
    settle();

    // Width and height below the minimum, alternating bit patterns.
    write_reg(c3vs_pkg::REG_IMAGE_WIDTH, 32'd0);
    write_reg(c3vs_pkg::REG_IMAGE_HEIGHT, 32'd1);
    write_reg(c3vs_pkg::REG_KERNEL_ROW0, 32'h007F_7F7F);
    write_reg(c3vs_pkg::REG_KERNEL_ROW1, 32'hFF55_AA01);
    write_reg(c3vs_pkg::REG_KERNEL_ROW2, 32'h00FF_0080);
    for (int n = 0; n < 9; n++) send_sample(n[0] ? 16'sh5555 : 16'shAAAA);
    settle();

    // Kernel swapped partway through a frame, right after its first result.
    write_reg(c3vs_pkg::REG_IMAGE_WIDTH, 32'd5);
    write_reg(c3vs_pkg::REG_IMAGE_HEIGHT, 32'd5);
    write_reg(c3vs_pkg::REG_KERNEL_ROW0, rand_kernel_row());
    repeat (13) send_sample(rand_sample());
    settle();
    write_reg(c3vs_pkg::REG_KERNEL_ROW1, rand_kernel_row());
    finish_frame();
    settle();

    // Full-height frame cut short: width shrinks and height drops below the
    // current row, so the frame ends at the end of this row.
    write_reg(c3vs_pkg::REG_IMAGE_WIDTH, 32'd8);
    write_reg(c3vs_pkg::REG_IMAGE_HEIGHT, 32'd65535);
    repeat (35) send_sample(rand_sample());
    settle();
    write_reg(c3vs_pkg::REG_IMAGE_WIDTH, 32'd6);
    write_reg(c3vs_pkg::REG_IMAGE_HEIGHT, 32'd2);
    finish_frame();
    settle();

    // Width above the maximum is clamped, so a short run stays inside row 0;
    // the frame then closes on a 3 by 3 geometry.
    write_reg(c3vs_pkg::REG_IMAGE_WIDTH, 32'h0000_07FF);
    write_reg(c3vs_pkg::REG_IMAGE_HEIGHT, 32'd0);
    for (int r = 0; r < KS; r++) write_reg(c3vs_pkg::reg_idx_t'(r), rand_kernel_row());
    repeat (20) send_sample(rand_sample());
    settle();
    write_reg(c3vs_pkg::REG_IMAGE_WIDTH, 32'd3);
    write_reg(c3vs_pkg::REG_IMAGE_HEIGHT, 32'd3);
    finish_frame();

    // Random small frames with random kernels and idling patterns.
    start = samples_sent;
    while (samples_sent - start < RANDOM_ITEMS) begin
      settle();
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 5;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      for (int r = 0; r < KS; r++) write_reg(c3vs_pkg::reg_idx_t'(r), rand_kernel_row());
      write_reg(c3vs_pkg::REG_IMAGE_WIDTH, $urandom_range(0, 12));
      write_reg(c3vs_pkg::REG_IMAGE_HEIGHT, $urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 30)) send_sample(rand_sample());
        settle();
        write_reg(c3vs_pkg::reg_idx_t'($urandom_range(0, KS - 1)), rand_kernel_row());
      end
      repeat ($urandom_range(1, 3)) finish_frame();
    end
    settle();

    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: conv3x3_valid_stream_unit.f
+incdir+hw/rtl
hw/rtl/c3vs_pkg.sv
hw/rtl/c3vs_line_buf.sv
hw/rtl/c3vs_window_mac.sv
hw/rtl/c3vs_out_fifo.sv
hw/rtl/conv3x3_valid_stream_unit.sv
hw/rtl/c3vs_checker.sv
tb/conv3x3_valid_stream_unit_tb.sv
